// File: rtl/flt_pkg.sv
// Shared types, constants and helpers for the filter life tracker.
package flt_pkg;

    localparam int CNT_BITS_DEFAULT = 32;
    localparam int LIFE_W           = 28;   // 16-bit hours * 3600
    localparam int PROD_W           = 35;   // 28-bit run * 100
    localparam int PCT_W            = 7;
    localparam int IND_W            = 2;
    localparam int QUOT_W           = 7;    // quotient below 100 whenever run is below life
    localparam int STEP_W           = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 17;

    localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
    localparam logic [PCT_W-1:0] FULL_PERCENT  = 7'd100;
    localparam logic [STEP_W-1:0] LAST_STEP    = 3'(QUOT_W - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GREASE_LIFE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARBON_LIFE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_INTV   = 3'd5;

    // operations
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTORE = 1'b1;

    // indication codes
    localparam logic [IND_W-1:0] IND_OK       = 2'd0;
    localparam logic [IND_W-1:0] IND_WARNING  = 2'd1;
    localparam logic [IND_W-1:0] IND_CRITICAL = 2'd2;

    typedef struct packed {
        logic [15:0] grease_life_hours;
        logic [15:0] carbon_life_hours;
        logic [6:0]  warning_percent;
        logic [6:0]  critical_percent;
        logic [11:0] poll_seconds;
        logic [16:0] save_interval_seconds;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              update;
        logic              life;
        logic              check;
        logic              divide;
        logic              store;
        logic              publish;
        logic              sel;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic [PCT_W-1:0] first_condition;
        logic [IND_W-1:0] first_indication;
        logic [PCT_W-1:0] second_condition;
        logic [IND_W-1:0] second_indication;
        logic [31:0]      total_seconds;
        logic             save_request;
    } res_t;

    function automatic logic [IND_W-1:0] ind_of(input logic [PCT_W-1:0] cond,
                                                 input logic [PCT_W-1:0] warn,
                                                 input logic [PCT_W-1:0] crit);
        logic [IND_W-1:0] ind;
        if (cond <= crit)
            ind = IND_CRITICAL;
        else if (cond <= warn)
            ind = IND_WARNING;
        else
            ind = IND_OK;
        return ind;
    endfunction

endpackage

// File: rtl/flt_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface flt_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [6:0]  fan_percent;
    logic [31:0] restored_seconds;

    modport source (output valid, output operation, output fan_percent,
                    output restored_seconds, input ready);
    modport sink   (input valid, input operation, input fan_percent,
                    input restored_seconds, output ready);
endinterface

interface flt_result_if;
    logic        valid;
    logic        ready;
    logic [6:0]  first_condition;
    logic [1:0]  first_indication;
    logic [6:0]  second_condition;
    logic [1:0]  second_indication;
    logic [31:0] total_seconds;
    logic        save_request;

    modport source (output valid, output first_condition, output first_indication,
                    output second_condition, output second_indication,
                    output total_seconds, output save_request, input ready);
    modport sink   (input valid, input first_condition, input first_indication,
                    input second_condition, input second_indication,
                    input total_seconds, input save_request, output ready);
endinterface

interface flt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/flt_cfg.sv
// Configuration register file.
module flt_cfg
    import flt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    flt_cfg_if.sink cfg,
    output cfg_t cfg_regs
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grease_life_hours     <= 16'd100;
            cfg_reg.carbon_life_hours     <= 16'd200;
            cfg_reg.warning_percent       <= 7'd20;
            cfg_reg.critical_percent      <= 7'd5;
            cfg_reg.poll_seconds          <= 12'd5;
            cfg_reg.save_interval_seconds <= 17'd60;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GREASE_LIFE: cfg_reg.grease_life_hours     <= cfg.data[15:0];
                REG_CARBON_LIFE: cfg_reg.carbon_life_hours     <= cfg.data[15:0];
                REG_WARNING:     cfg_reg.warning_percent       <= cfg.data[6:0];
                REG_CRITICAL:    cfg_reg.critical_percent      <= cfg.data[6:0];
                REG_POLL:        cfg_reg.poll_seconds          <= cfg.data[11:0];
                REG_SAVE_INTV:   cfg_reg.save_interval_seconds <= cfg.data;
                default:         ;  // unknown index: ignored
            endcase
        end
    end

endmodule

// File: rtl/flt_dp.sv
// Datapath: run counters, life products, shared restoring divider, result register.
module flt_dp
    import flt_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  cfg_t        cfg_regs,
    input  logic        item_operation,
    input  logic [6:0]  item_fan_percent,
    input  logic [31:0] item_restored_seconds,
    output res_t        res
);

    localparam int W = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
    localparam logic [COUNTER_BITS:0] CNT_MAX = {1'b0, {COUNTER_BITS{1'b1}}};

    // captured item
    logic                    op_reg;
    logic                    fan_on_reg;
    logic [31:0]             rest_reg;

    // state
    logic [COUNTER_BITS-1:0] run_reg;
    logic [COUNTER_BITS-1:0] since_reg;
    logic                    save_reg;

    // per-filter work
    logic [LIFE_W-1:0]       life_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    big_reg;
    logic                    exceed_reg;
    logic [PROD_W-1:0]       rem_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [PCT_W-1:0]        cond0_reg;
    logic [PCT_W-1:0]        cond1_reg;
    res_t                    res_reg;

    logic [COUNTER_BITS:0]   run_sum;
    logic [COUNTER_BITS:0]   since_sum;
    logic [COUNTER_BITS-1:0] run_sat;
    logic [COUNTER_BITS-1:0] since_sat;
    logic                    save_hit;
    logic [W-1:0]            rest_w;
    logic [W-1:0]            max_w;
    logic [W-1:0]            rest_sat;
    logic [W-1:0]            run_w;
    logic [LIFE_W-1:0]       run_lo;
    logic [15:0]             hours_sel;
    logic [PROD_W-1:0]       shifted;
    logic [PCT_W-1:0]        cond_new;

    assign run_sum   = {1'b0, run_reg} + (COUNTER_BITS+1)'(cfg_regs.poll_seconds);
    assign since_sum = {1'b0, since_reg} + (COUNTER_BITS+1)'(cfg_regs.poll_seconds);
    assign run_sat   = (run_sum > CNT_MAX) ? CNT_MAX[COUNTER_BITS-1:0]
                                           : run_sum[COUNTER_BITS-1:0];
    assign since_sat = (since_sum > CNT_MAX) ? CNT_MAX[COUNTER_BITS-1:0]
                                             : since_sum[COUNTER_BITS-1:0];
    assign save_hit  = since_sat >= COUNTER_BITS'(cfg_regs.save_interval_seconds);

    assign rest_w   = W'(rest_reg);
    assign max_w    = W'(CNT_MAX);
    assign rest_sat = (rest_w > max_w) ? max_w : rest_w;

    assign run_w     = W'(run_reg);
    assign run_lo    = run_w[LIFE_W-1:0];
    assign hours_sel = cmd.sel ? cfg_regs.carbon_life_hours : cfg_regs.grease_life_hours;
    assign shifted   = PROD_W'(life_reg) << cmd.step;
    assign cond_new  = exceed_reg ? '0 : FULL_PERCENT - quot_reg;

    assign res = res_reg;

    // control state: counters reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            since_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (op_reg == OP_RESTORE)
            begin
                run_reg   <= rest_sat[COUNTER_BITS-1:0];
                since_reg <= '0;
            end
            else if (fan_on_reg)
            begin
                run_reg   <= run_sat;
                since_reg <= save_hit ? '0 : since_sat;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= item_operation;
            fan_on_reg <= |item_fan_percent;
            rest_reg   <= item_restored_seconds;
        end
        if (cmd.update)
            save_reg <= (op_reg == OP_TICK) && fan_on_reg && save_hit;
        if (cmd.life)
        begin
            life_reg <= LIFE_W'(hours_sel) * LIFE_W'(SECS_PER_HOUR);
            prod_reg <= PROD_W'(run_lo) * PROD_W'(FULL_PERCENT);
            big_reg  <= run_w >= (W'(1) << LIFE_W);
        end
        if (cmd.check)
        begin
            exceed_reg <= big_reg || (run_lo >= life_reg);
            rem_reg    <= prod_reg;
            quot_reg   <= '0;
        end
        if (cmd.divide && (rem_reg >= shifted))
        begin
            rem_reg  <= rem_reg - shifted;
            quot_reg <= quot_reg | (QUOT_W'(1) << cmd.step);
        end
        if (cmd.store)
        begin
            if (cmd.sel)
                cond1_reg <= cond_new;
            else
                cond0_reg <= cond_new;
        end
        if (cmd.publish)
        begin
            res_reg.first_condition   <= cond0_reg;
            res_reg.first_indication  <= ind_of(cond0_reg, cfg_regs.warning_percent,
                                                cfg_regs.critical_percent);
            res_reg.second_condition  <= cond1_reg;
            res_reg.second_indication <= ind_of(cond1_reg, cfg_regs.warning_percent,
                                                cfg_regs.critical_percent);
            res_reg.total_seconds     <= (run_w > W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                    : run_w[31:0];
            res_reg.save_request      <= save_reg;
        end
    end

endmodule

// File: rtl/flt_ctrl.sv
// Controller: sequences counter update, two life divisions and result hand-off.
module flt_ctrl
    import flt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_LIFE   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_STORE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              publish;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign publish   = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd         = '0;
        cmd.load    = in_ready && in_valid;
        cmd.update  = (state_reg == S_UPDATE);
        cmd.life    = (state_reg == S_LIFE);
        cmd.check   = (state_reg == S_CHECK);
        cmd.divide  = (state_reg == S_DIV);
        cmd.store   = (state_reg == S_STORE);
        cmd.publish = publish;
        cmd.sel     = sel_reg;
        cmd.step    = step_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                sel_next   = 1'b0;
                state_next = S_LIFE;
            end
            S_LIFE:
                state_next = S_CHECK;
            S_CHECK:
            begin
                step_next  = LAST_STEP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == '0)
                    state_next = S_STORE;
                else
                    step_next = step_reg - 1'b1;
            end
            S_STORE:
            begin
                if (sel_reg)
                    state_next = S_FINISH;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = S_LIFE;
                end
            end
            S_FINISH:
            begin
                if (publish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/filter_life_tracker.sv
// Filter service-life meter for two filters: top level.
//
// Channels (valid/ready, a word moves when both are high at a rising edge):
//   items   - operation (0 poll tick, 1 restore), fan_percent, restored_seconds
//   results - per-filter remaining percent and indication, total run seconds,
//             save request; exactly one result word per item word
//   cfg     - register writes (index, data); always ready, unknown indexes dropped
// Sequence: after an item is accepted, the UPDATE state updates the run and
//   since-save counters, each filter then goes through life product, exceed
//   check, 7-step restoring division and store on one shared divider, and
//   the FINISH state loads the output register. A new item is taken only in
//   the idle state, after the previous one has reached the output register.
// The result sits in an output register: a new item is accepted while the
//   previous result waits; if the receiver stalls, the finished item waits in
//   the last step until the output register frees up, and items stop there.
// Reset (rst_n, async, active low): counters clear, config takes its defaults.
// Config must be written only while no item is in flight.
module filter_life_tracker
    import flt_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    flt_item_if.sink     items,
    flt_result_if.source results,
    flt_cfg_if.sink      cfg
);

    cfg_t cfg_regs;
    cmd_t cmd;
    res_t res;

    flt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    flt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    flt_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .cfg_regs              (cfg_regs),
        .item_operation        (items.operation),
        .item_fan_percent      (items.fan_percent),
        .item_restored_seconds (items.restored_seconds),
        .res                   (res)
    );

    // break out the result word onto the channel
    assign results.first_condition   = res.first_condition;
    assign results.first_indication  = res.first_indication;
    assign results.second_condition  = res.second_condition;
    assign results.second_indication = res.second_indication;
    assign results.total_seconds     = res.total_seconds;
    assign results.save_request      = res.save_request;

endmodule

// File: tb/filter_life_tracker_tb.sv
// Self-checking testbench for the two-filter service-life meter.
module filter_life_tracker_tb;
    import flt_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int COUNTER_BITS    = 32;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 222;  // about 1800 random words in all
    localparam int DRAIN_PAUSE     = 30;   // pause longer than one item takes through the block

    // saturation point of the run and since-save counters
    localparam logic [63:0] CNT_MAX = (64'd1 << COUNTER_BITS) - 64'd1;

    localparam cfg_t RESET_CFG = '{grease_life_hours:     16'd100,
                                   carbon_life_hours:     16'd200,
                                   warning_percent:       7'd20,
                                   critical_percent:      7'd5,
                                   poll_seconds:          12'd5,
                                   save_interval_seconds: 17'd60};

    // one row of the directed plan: a register write or an item word,
    // the latter with an optional hand-written expected result
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  reg_idx;
        logic [16:0] reg_data;
        logic        op;
        logic [6:0]  fan;
        logic [31:0] restored;
        logic        typed;
        res_t        want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    flt_item_if   items_ch ();
    flt_result_if results_ch ();
    flt_cfg_if    cfg_ch ();

    filter_life_tracker #(.COUNTER_BITS(COUNTER_BITS)) uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Meter predictor: own copy of the settings and the two counters
    // ------------------------------------------------------------------
    cfg_t        meter_cfg;
    logic [63:0] run_secs;
    logic [63:0] unsaved_secs;

    res_t        due_readings [$];   // results owed by the block, oldest first
    int          fault_count;
    bit          calm_source;        // no sender gaps in this phase
    bit          calm_sink;          // no receiver stalls in this phase
    plan_row_t   plan [$];

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > CNT_MAX) ? CNT_MAX : s;
    endfunction

    // remaining life in percent; a zero-hour life counts as already spent
    function automatic logic [6:0] percent_left(logic [63:0] run, logic [15:0] hours);
        logic [63:0] span;
        span = 64'(hours) * 64'(SECS_PER_HOUR);
        if (run >= span)
            return 7'd0;
        return 7'(64'(FULL_PERCENT) - (run * 64'(FULL_PERCENT)) / span);
    endfunction

    // critical wins over warning when both thresholds match
    function automatic logic [1:0] grade(logic [6:0] cond);
        if (cond <= meter_cfg.critical_percent)
            return IND_CRITICAL;
        if (cond <= meter_cfg.warning_percent)
            return IND_WARNING;
        return IND_OK;
    endfunction

    function automatic res_t meter_step(logic op, logic [6:0] fan, logic [31:0] rest);
        res_t r;
        logic save;
        save = 1'b0;
        if (op == OP_RESTORE)
        begin
            run_secs     = (64'(rest) > CNT_MAX) ? CNT_MAX : 64'(rest);
            unsaved_secs = 64'd0;
        end
        else if (fan != 7'd0)
        begin
            run_secs     = sat_add(run_secs, 64'(meter_cfg.poll_seconds));
            unsaved_secs = sat_add(unsaved_secs, 64'(meter_cfg.poll_seconds));
            // a zero interval trips on every running tick, even with zero poll
            if (unsaved_secs >= 64'(meter_cfg.save_interval_seconds))
            begin
                save         = 1'b1;
                unsaved_secs = 64'd0;
            end
        end
        r.first_condition   = percent_left(run_secs, meter_cfg.grease_life_hours);
        r.first_indication  = grade(r.first_condition);
        r.second_condition  = percent_left(run_secs, meter_cfg.carbon_life_hours);
        r.second_indication = grade(r.second_condition);
        r.total_seconds     = (run_secs > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_secs[31:0];
        r.save_request      = save;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Plan rows
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [2:0] idx, logic [16:0] data);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic plan_row_t item_row(logic op, logic [6:0] fan, logic [31:0] rest);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_ITEM;
        row.op       = op;
        row.fan      = fan;
        row.restored = rest;
        return row;
    endfunction

    function automatic plan_row_t known_row(logic op, logic [6:0] fan, logic [31:0] rest,
                                            logic [6:0] c1, logic [1:0] i1,
                                            logic [6:0] c2, logic [1:0] i2,
                                            logic [31:0] total, logic save);
        plan_row_t row;
        row       = item_row(op, fan, rest);
        row.typed = 1'b1;
        row.want  = '{first_condition: c1, first_indication: i1,
                      second_condition: c2, second_indication: i2,
                      total_seconds: total, save_request: save};
        return row;
    endfunction

    // mostly back to back, often short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_life();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($urandom_range(1, 30));
        if (r < 9)
            return 16'($urandom_range(1, 2000));
        return 16'($urandom_range(1, 65535));
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left in the time step of a rising
    // edge; send_item and write_reg leave valid high so that a following
    // word can go out back to back without a second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(logic op, logic [6:0] fan, logic [31:0] rest,
                             logic typed, res_t want);
        int unsigned gap;
        res_t        predicted;
        gap = calm_source ? 0 : pick_gap();
        if (gap != 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid            <= 1'b1;
        items_ch.operation        <= op;
        items_ch.fan_percent      <= fan;
        items_ch.restored_seconds <= rest;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        // word taken at this edge: advance the predictor
        predicted = meter_step(op, fan, rest);
        due_readings.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_GREASE_LIFE: meter_cfg.grease_life_hours     = data[15:0];
            REG_CARBON_LIFE: meter_cfg.carbon_life_hours     = data[15:0];
            REG_WARNING:     meter_cfg.warning_percent       = data[6:0];
            REG_CRITICAL:    meter_cfg.critical_percent      = data[6:0];
            REG_POLL:        meter_cfg.poll_seconds          = data[11:0];
            REG_SAVE_INTV:   meter_cfg.save_interval_seconds = data[16:0];
            default:         ;  // unknown index: the block drops it
        endcase
    endtask

    // block must be idle before settings change: all results back, then
    // a pause of about one item latency
    task automatic settle();
        items_ch.valid <= 1'b0;
        while (due_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic load_settings(cfg_t s);
        settle();
        write_reg(REG_GREASE_LIFE, 17'(s.grease_life_hours));
        write_reg(REG_CARBON_LIFE, 17'(s.carbon_life_hours));
        write_reg(REG_WARNING,     17'(s.warning_percent));
        write_reg(REG_CRITICAL,    17'(s.critical_percent));
        write_reg(REG_POLL,        17'(s.poll_seconds));
        write_reg(REG_SAVE_INTV,   s.save_interval_seconds);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock, result receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls of mixed length, none in calm phases
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                results_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
                if (!calm_sink && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (due_readings.size() == 0)
            begin
                $error("result word with nothing pending: total_seconds %0d",
                       results_ch.total_seconds);
                fault_count++;
            end
            else
            begin
                want = due_readings.pop_front();
                compare_field("first_condition", want.first_condition,
                              results_ch.first_condition);
                compare_field("first_indication", want.first_indication,
                              results_ch.first_indication);
                compare_field("second_condition", want.second_condition,
                              results_ch.second_condition);
                compare_field("second_indication", want.second_indication,
                              results_ch.second_indication);
                compare_field("total_seconds", want.total_seconds,
                              results_ch.total_seconds);
                compare_field("save_request", want.save_request,
                              results_ch.save_request);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("filter_life_tracker_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t        s;
        logic        op;
        logic [6:0]  fan;
        logic [31:0] rest;
        int unsigned r;
        int unsigned span;

        fault_count  = 0;
        calm_source  = 1'b0;
        calm_sink    = 1'b0;
        meter_cfg    = RESET_CFG;
        run_secs     = 64'd0;
        unsaved_secs = 64'd0;

        rst_n                     <= 1'b0;
        items_ch.valid            <= 1'b0;
        items_ch.operation        <= OP_TICK;
        items_ch.fan_percent      <= 7'd0;
        items_ch.restored_seconds <= 32'd0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.index              <= REG_GREASE_LIFE;
        cfg_ch.data               <= 17'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed plan -------------------------------------------
        // reset settings: grease 100 h, carbon 200 h, warn 20, crit 5,
        // poll 5 s, save every 60 s
        plan.push_back(known_row(OP_TICK, 7'd0, 32'd0,
                                 7'd100, IND_OK, 7'd100, IND_OK, 32'd0, 1'b0));
        plan.push_back(known_row(OP_TICK, 7'd100, 32'd0,
                                 7'd100, IND_OK, 7'd100, IND_OK, 32'd5, 1'b0));
        // counter at its top, then a tick must not wrap it
        plan.push_back(known_row(OP_RESTORE, 7'd0, 32'hFFFF_FFFF,
                                 7'd0, IND_CRITICAL, 7'd0, IND_CRITICAL,
                                 32'hFFFF_FFFF, 1'b0));
        plan.push_back(known_row(OP_TICK, 7'd1, 32'd0,
                                 7'd0, IND_CRITICAL, 7'd0, IND_CRITICAL,
                                 32'hFFFF_FFFF, 1'b0));
        // one second short of grease life, warning edge, critical edge
        plan.push_back(item_row(OP_RESTORE, 7'd55, 32'd359999));
        plan.push_back(known_row(OP_RESTORE, 7'd0, 32'd288000,
                                 7'd20, IND_WARNING, 7'd60, IND_OK, 32'd288000, 1'b0));
        plan.push_back(item_row(OP_RESTORE, 7'd127, 32'd342000));
        plan.push_back(known_row(OP_RESTORE, 7'd0, 32'd360000,
                                 7'd0, IND_CRITICAL, 7'd50, IND_OK, 32'd360000, 1'b0));
        // save request on the second running tick; restored ignored on ticks
        plan.push_back(cfg_row(REG_SAVE_INTV, 17'd10));
        plan.push_back(item_row(OP_TICK, 7'd100, 32'hFFFF_FFFF));
        plan.push_back(item_row(OP_TICK, 7'd64, 32'd0));
        // zero poll period: nothing added, interval not reached
        plan.push_back(cfg_row(REG_POLL, 17'd0));
        plan.push_back(item_row(OP_TICK, 7'd1, 32'd0));
        // zero interval: every running tick requests a save, fan off never
        plan.push_back(cfg_row(REG_SAVE_INTV, 17'd0));
        plan.push_back(item_row(OP_TICK, 7'd100, 32'd0));
        plan.push_back(item_row(OP_TICK, 7'd0, 32'd0));
        // zero-hour life, then writes to unused indexes that must change nothing
        plan.push_back(cfg_row(REG_GREASE_LIFE, 17'd0));
        plan.push_back(cfg_row(3'd6, 17'h1FFFF));
        plan.push_back(cfg_row(3'd7, 17'd0));
        plan.push_back(item_row(OP_TICK, 7'd0, 32'd0));
        // largest lives, long periods; warning threshold covers full life
        plan.push_back(cfg_row(REG_GREASE_LIFE, 17'd65535));
        plan.push_back(cfg_row(REG_CARBON_LIFE, 17'd65535));
        plan.push_back(cfg_row(REG_WARNING, 17'd100));
        plan.push_back(cfg_row(REG_CRITICAL, 17'd0));
        plan.push_back(cfg_row(REG_POLL, 17'd3600));
        plan.push_back(cfg_row(REG_SAVE_INTV, 17'd86400));
        plan.push_back(known_row(OP_RESTORE, 7'd0, 32'd0,
                                 7'd100, IND_WARNING, 7'd100, IND_WARNING, 32'd0, 1'b0));
        plan.push_back(item_row(OP_TICK, 7'd100, 32'd0));
        // both thresholds matching: critical takes priority
        plan.push_back(cfg_row(REG_WARNING, 17'd0));
        plan.push_back(cfg_row(REG_CRITICAL, 17'd100));
        plan.push_back(item_row(OP_TICK, 7'd50, 32'd0));
        // smallest lives and periods
        plan.push_back(cfg_row(REG_GREASE_LIFE, 17'd1));
        plan.push_back(cfg_row(REG_CARBON_LIFE, 17'd1));
        plan.push_back(cfg_row(REG_WARNING, 17'd0));
        plan.push_back(cfg_row(REG_CRITICAL, 17'd0));
        plan.push_back(cfg_row(REG_POLL, 17'd1));
        plan.push_back(cfg_row(REG_SAVE_INTV, 17'd1));
        plan.push_back(known_row(OP_RESTORE, 7'd0, 32'd3599,
                                 7'd1, IND_OK, 7'd1, IND_OK, 32'd3599, 1'b0));
        plan.push_back(known_row(OP_TICK, 7'd100, 32'd0,
                                 7'd0, IND_CRITICAL, 7'd0, IND_CRITICAL, 32'd3600, 1'b1));
        plan.push_back(item_row(OP_RESTORE, 7'd0, 32'h8000_0000));
        plan.push_back(item_row(OP_TICK, 7'd0, 32'hAAAA_AAAA));

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (i == 0 || plan[i-1].kind != ROW_CFG)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
                if (i == plan.size() - 1 || plan[i+1].kind != ROW_CFG)
                    cfg_ch.valid <= 1'b0;
            end
            else
            begin
                send_item(plan[i].op, plan[i].fan, plan[i].restored,
                          plan[i].typed, plan[i].want);
            end
        end

        // --- random phases ---------------------------------------------
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: s = '{grease_life_hours: 16'd1, carbon_life_hours: 16'd2,
                         warning_percent: 7'd20, critical_percent: 7'd5,
                         poll_seconds: 12'd60, save_interval_seconds: 17'd300};
                1: s = '{grease_life_hours: 16'd65535, carbon_life_hours: 16'd65535,
                         warning_percent: 7'd100, critical_percent: 7'd100,
                         poll_seconds: 12'd3600, save_interval_seconds: 17'd86400};
                2: s = '{grease_life_hours: 16'd1, carbon_life_hours: 16'd1,
                         warning_percent: 7'd0, critical_percent: 7'd0,
                         poll_seconds: 12'd1, save_interval_seconds: 17'd1};
                default:
                begin
                    s.grease_life_hours = pick_life();
                    s.carbon_life_hours = pick_life();
                    s.warning_percent   = 7'($urandom_range(0, 100));
                    s.critical_percent  = 7'($urandom_range(0, 100));
                    s.poll_seconds      = ($urandom_range(0, 1) == 0)
                                          ? 12'($urandom_range(1, 600))
                                          : 12'($urandom_range(1, 3600));
                    span = 8 * s.poll_seconds;
                    if (span > 86400)
                        span = 86400;
                    s.save_interval_seconds = ($urandom_range(0, 1) == 0)
                                              ? 17'($urandom_range(1, span))
                                              : 17'($urandom_range(1, 86400));
                end
            endcase
            calm_source = (phase == 3) || ($urandom_range(0, 3) == 0);
            calm_sink   = (phase == 3) || ($urandom_range(0, 3) == 0);
            load_settings(s);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    // poll tick; restored field is noise here
                    op   = OP_TICK;
                    fan  = ($urandom_range(0, 4) == 0) ? 7'd0 : 7'($urandom_range(1, 100));
                    rest = $urandom;
                end
                else
                begin
                    op   = OP_RESTORE;
                    fan  = 7'($urandom_range(0, 100));
                    r    = $urandom_range(0, 99);
                    span = 3600 * (($urandom_range(0, 1) == 0) ? meter_cfg.grease_life_hours
                                                                : meter_cfg.carbon_life_hours);
                    if (r < 45)
                        rest = $urandom_range(0, span + span / 8);  // across the life span
                    else if (r < 70)
                        rest = $urandom_range(0, 5000);
                    else if (r < 85)
                        rest = $urandom;
                    else
                        rest = 32'hFFFF_FFFF - $urandom_range(0, 20000);  // near the top
                end
                send_item(op, fan, rest, 1'b0, '0);
            end
        end

        // --- wind down -------------------------------------------------
        items_ch.valid <= 1'b0;
        while (due_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);

        if (fault_count == 0)
            $display("filter_life_tracker_tb: clean");
        else
            $display("filter_life_tracker_tb: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/flt_pkg.sv
rtl/flt_if.sv
rtl/flt_cfg.sv
rtl/flt_dp.sv
rtl/flt_ctrl.sv
rtl/filter_life_tracker.sv
tb/filter_life_tracker_tb.sv
